// ===== sv/tlla_pkg.sv =====
// Shared types and constants for the toroidal life-like automaton step block.
// No dependencies; every other file takes what it needs from here, by scoped name or by import.
package tlla_pkg;

	localparam int ROW_BITS   = 64;
	localparam int GW_BITS    = 7;
	localparam int MASK_BITS  = 9;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	localparam int DEF_MAX_WIDTH = 64;
	localparam int DEF_MAX_ROWS  = 64;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BIRTH_MASK = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEATH_MASK = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DIAGONAL   = 8'd3;

	localparam logic [GW_BITS-1:0]   RST_GRID_WIDTH = 7'd64;
	localparam logic [MASK_BITS-1:0] RST_BIRTH_MASK = 9'd8;
	localparam logic [MASK_BITS-1:0] RST_DEATH_MASK = 9'd499;
	localparam logic                 RST_DIAGONAL   = 1'b1;

	typedef struct packed {
		logic [MASK_BITS-1:0] birth;
		logic [MASK_BITS-1:0] death;
		logic                 diag;
	} rule_t;

endpackage

// ===== sv/tlla_if.sv =====
// Handshake channels of the automaton step block: row input, result output, register writes.
// Depends on tlla_pkg for payload widths.
interface tlla_in_if;
	logic                         valid;
	logic                         ready;
	logic [tlla_pkg::ROW_BITS-1:0] row_cells;
	logic                         final_row;

	modport source (output valid, output row_cells, output final_row, input ready);
	modport sink   (input valid, input row_cells, input final_row, output ready);
endinterface

interface tlla_out_if;
	logic                         valid;
	logic                         ready;
	logic [tlla_pkg::ROW_BITS-1:0] next_cells;
	logic                         last_of_frame;
	logic                         rows_dropped;

	modport source (output valid, output next_cells, output last_of_frame,
		output rows_dropped, input ready);
	modport sink   (input valid, input next_cells, input last_of_frame,
		input rows_dropped, output ready);
endinterface

interface tlla_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [tlla_pkg::CFG_IDX_W-1:0]  index;
	logic [tlla_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/toroidal_life_like_automaton_step.sv =====
// Rows are taken one per cycle while a frame loads; nothing is emitted until the final row.
// After the final row's beat the store is read into the three-row window and each result
// row is registered; rows then follow one per cycle while the sink takes them: the row
// store has one read port and the window needs h+2 reads, so input is held off while a generation runs.
// Reset clears the row count, the overflow flag and the pipeline control and loads the
// register defaults; the row store itself is not cleared.
module toroidal_life_like_automaton_step #(
	parameter int MAX_WIDTH = tlla_pkg::DEF_MAX_WIDTH,
	parameter int MAX_ROWS  = tlla_pkg::DEF_MAX_ROWS
) (
	input  logic       clk,
	input  logic       arst_n,
	tlla_in_if.sink    frame,
	tlla_out_if.source result,
	tlla_cfg_if.sink   cfg
);
	localparam int WW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW = $clog2(MAX_ROWS + 1);
	localparam int KW = $clog2(MAX_ROWS + 3);

	typedef enum logic [1:0] {
		ST_LOAD = 2'b01,
		ST_GEN  = 2'b10
	} state_t;

	state_t state_q;

	// configuration registers
	logic [tlla_pkg::GW_BITS-1:0] grid_width_q;
	tlla_pkg::rule_t              rule_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q <= tlla_pkg::RST_GRID_WIDTH;
			rule_q.birth <= tlla_pkg::RST_BIRTH_MASK;
			rule_q.death <= tlla_pkg::RST_DEATH_MASK;
			rule_q.diag  <= tlla_pkg::RST_DIAGONAL;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				tlla_pkg::REG_GRID_WIDTH: grid_width_q <= cfg.data[tlla_pkg::GW_BITS-1:0];
				tlla_pkg::REG_BIRTH_MASK: rule_q.birth <= cfg.data[tlla_pkg::MASK_BITS-1:0];
				tlla_pkg::REG_DEATH_MASK: rule_q.death <= cfg.data[tlla_pkg::MASK_BITS-1:0];
				tlla_pkg::REG_DIAGONAL:   rule_q.diag  <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// clamp the width: zero acts as one, above the lane count acts as the lane count
	logic [WW-1:0] wm1_cfg;

	always_comb begin
		if (grid_width_q == '0) begin
			wm1_cfg = '0;
		end else if (grid_width_q > tlla_pkg::GW_BITS'(MAX_WIDTH)) begin
			wm1_cfg = WW'(MAX_WIDTH - 1);
		end else begin
			wm1_cfg = WW'(grid_width_q - tlla_pkg::GW_BITS'(1));
		end
	end

	// load side
	logic          in_beat;
	logic          store_full;
	logic [CW-1:0] rows_loaded_q;
	logic          ovf_q;
	logic [CW-1:0] h_q;
	logic          drop_q;
	logic [WW-1:0] wm1_q;

	assign frame.ready = (state_q == ST_LOAD);
	assign in_beat     = frame.valid && frame.ready;
	assign store_full  = (rows_loaded_q == CW'(MAX_ROWS));

	// generation side
	logic                 advance;
	logic [KW-1:0]        k_q;
	logic [KW-1:0]        k_m1;
	logic                 issue;
	logic [AW-1:0]        rd_addr;
	logic [MAX_WIDTH-1:0] rd_s1;
	logic                 rd_vld_s1;
	logic [MAX_WIDTH-1:0] win_up_q, win_mid_q;
	logic [1:0]           fill_q;
	logic [CW-1:0]        y_q;
	logic                 produce;
	logic                 last_row;
	logic [MAX_WIDTH-1:0] next_row;

	logic [MAX_WIDTH-1:0] out_cells_q;
	logic                 out_vld_q;
	logic                 out_last_q;
	logic                 out_drop_q;

	assign advance  = !out_vld_q || result.ready;
	assign issue    = (state_q == ST_GEN) && (k_q <= KW'(h_q) + KW'(1));
	assign k_m1     = k_q - KW'(1);
	assign produce  = (state_q == ST_GEN) && advance && rd_vld_s1 && (fill_q == 2'd2);
	assign last_row = (y_q == h_q - CW'(1));

	// read order: row h-1, rows 0 .. h-1, then row 0 again
	always_comb begin
		if (k_q == '0) begin
			rd_addr = AW'(h_q - CW'(1));
		end else if (k_m1 == KW'(h_q)) begin
			rd_addr = '0;
		end else begin
			rd_addr = k_m1[AW-1:0];
		end
	end

	// row store
	logic [MAX_WIDTH-1:0] frame_mem [MAX_ROWS];

	always_ff @(posedge clk) begin
		if (in_beat && !store_full) begin
			frame_mem[rows_loaded_q[AW-1:0]] <= frame.row_cells[MAX_WIDTH-1:0];
		end
		if (issue && advance) begin
			rd_s1 <= frame_mem[rd_addr];
		end
	end

	tlla_row #(
		.MAX_WIDTH (MAX_WIDTH),
		.WW        (WW)
	) u_row (
		.up   (win_up_q),
		.mid  (win_mid_q),
		.down (rd_s1),
		.wm1  (wm1_q),
		.rule (rule_q),
		.next (next_row)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_LOAD;
			rows_loaded_q <= '0;
			ovf_q         <= 1'b0;
			h_q           <= '0;
			drop_q        <= 1'b0;
			wm1_q         <= '0;
			k_q           <= '0;
			rd_vld_s1     <= 1'b0;
			fill_q        <= '0;
			y_q           <= '0;
			out_vld_q     <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (in_beat) begin
						if (!store_full) begin
							rows_loaded_q <= rows_loaded_q + CW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (frame.final_row) begin
							state_q <= ST_GEN;
							h_q     <= store_full ? rows_loaded_q : rows_loaded_q + CW'(1);
							drop_q  <= ovf_q || store_full;
							wm1_q   <= wm1_cfg;
							k_q     <= '0;
							fill_q  <= '0;
							y_q     <= '0;
						end
					end
				end
				ST_GEN: begin
					if (advance) begin
						rd_vld_s1 <= issue;
						if (issue) begin
							k_q <= k_q + KW'(1);
						end
						if (rd_vld_s1 && fill_q != 2'd2) begin
							fill_q <= fill_q + 2'd1;
						end
						if (produce) begin
							y_q <= y_q + CW'(1);
							if (last_row) begin
								// frame done: start the next one
								state_q       <= ST_LOAD;
								rows_loaded_q <= '0;
								ovf_q         <= 1'b0;
							end
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase

			if (result.valid && result.ready) begin
				out_vld_q <= 1'b0;
			end
			if (produce) begin
				out_vld_q <= 1'b1;
			end
		end
	end

	// window shift and result payload
	always_ff @(posedge clk) begin
		if ((state_q == ST_GEN) && advance && rd_vld_s1) begin
			win_up_q  <= win_mid_q;
			win_mid_q <= rd_s1;
		end
		if (produce) begin
			out_cells_q <= next_row;
			out_last_q  <= last_row;
			out_drop_q  <= drop_q;
		end
	end

	assign result.valid         = out_vld_q;
	assign result.next_cells    = tlla_pkg::ROW_BITS'(out_cells_q);
	assign result.last_of_frame = out_last_q;
	assign result.rows_dropped  = out_drop_q;

`ifndef NO_ASSERTIONS
	a_rows_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rows_loaded_q <= CW'(MAX_ROWS))
		else $error("row count beyond store depth");

	a_issue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_GEN) |-> (k_q <= KW'(h_q) + KW'(2)))
		else $error("read sequencer ran past the frame");

	a_gen_exit: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_LOAD) && $past(state_q == ST_GEN))
		|-> (rows_loaded_q == '0) && !ovf_q && !rd_vld_s1)
		else $error("generation ended with work left or state not cleared");

	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) |-> !rd_vld_s1)
		else $error("store read in flight while loading");

	a_frame_height: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_GEN) |-> (h_q != '0) && (y_q < h_q))
		else $error("output row index outside the frame");
`endif
endmodule

// ===== sv/tlla_lane.sv =====
// One cell lane: neighbour count and birth/death rule lookup for a single cell.
// Depends on tlla_pkg (rule_t).
module tlla_lane (
	input  logic [2:0]      up,
	input  logic [2:0]      mid,
	input  logic [2:0]      down,
	input  tlla_pkg::rule_t rule,
	output logic            alive
);
	// bit 0 is the left neighbour column, bit 1 the cell's column, bit 2 the right
	logic [3:0]  orth_cnt;
	logic [3:0]  diag_cnt;
	logic [3:0]  count;
	logic [15:0] birth_ext;
	logic [15:0] death_ext;

	assign orth_cnt = 4'(up[1]) + 4'(mid[0]) + 4'(mid[2]) + 4'(down[1]);
	assign diag_cnt = 4'(up[0]) + 4'(up[2]) + 4'(down[0]) + 4'(down[2]);
	assign count    = rule.diag ? (orth_cnt + diag_cnt) : orth_cnt;

	assign birth_ext = 16'(rule.birth);
	assign death_ext = 16'(rule.death);

	assign alive = mid[1] ? ~death_ext[count] : birth_ext[count];
endmodule

// ===== sv/tlla_row.sv =====
// Next-generation row: MAX_WIDTH cell lanes with horizontal wrap, merged into one row
// and cleared above the grid width. Depends on tlla_pkg and tlla_lane.
module tlla_row #(
	parameter int MAX_WIDTH = tlla_pkg::DEF_MAX_WIDTH,
	parameter int WW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
	input  logic [MAX_WIDTH-1:0] up,
	input  logic [MAX_WIDTH-1:0] mid,
	input  logic [MAX_WIDTH-1:0] down,
	input  logic [WW-1:0]        wm1,
	input  tlla_pkg::rule_t      rule,
	output logic [MAX_WIDTH-1:0] next
);
	logic                 up_last, mid_last, down_last;
	logic [MAX_WIDTH-1:0] alive;

	// the last cell in use is the left neighbour of cell 0
	assign up_last   = up[wm1];
	assign mid_last  = mid[wm1];
	assign down_last = down[wm1];

	for (genvar x = 0; x < MAX_WIDTH; x++) begin : g_lane
		logic [2:0] u, m, d;
		logic       at_edge;

		assign at_edge = (WW'(x) == wm1);

		if (x == 0) begin : g_first
			assign u[0] = up_last;
			assign m[0] = mid_last;
			assign d[0] = down_last;
		end else begin : g_rest
			assign u[0] = up[x-1];
			assign m[0] = mid[x-1];
			assign d[0] = down[x-1];
		end

		assign u[1] = up[x];
		assign m[1] = mid[x];
		assign d[1] = down[x];
		assign u[2] = at_edge ? up[0]   : up[(x+1) % MAX_WIDTH];
		assign m[2] = at_edge ? mid[0]  : mid[(x+1) % MAX_WIDTH];
		assign d[2] = at_edge ? down[0] : down[(x+1) % MAX_WIDTH];

		tlla_lane u_lane (
			.up    (u),
			.mid   (m),
			.down  (d),
			.rule  (rule),
			.alive (alive[x])
		);

		// merge: drop cells beyond the grid width
		assign next[x] = alive[x] & (WW'(x) <= wm1);
	end
endmodule

// ===== tb/sv/tlla_step_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the toroidal automaton step block: follows row and register beats, predicts
// every next-generation row and checks the result channel in order. Depends on tlla_pkg, tlla_if.
module tlla_step_checker (
	input  logic clk,
	input  logic arst_n,
	tlla_in_if   frame,
	tlla_out_if  result,
	tlla_cfg_if  cfg,
	output int   fail_count,
	output int   pending
);
	import tlla_pkg::*;

	localparam int STORE_ROWS  = DEF_MAX_ROWS;
	localparam int MAX_W       = DEF_MAX_WIDTH;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [ROW_BITS-1:0] cells;
		logic                last;
		logic                dropped;
	} gen_row_t;

	logic [ROW_BITS-1:0] row_store [STORE_ROWS];
	int                  rows_held;
	logic                overflowed;
	logic [GW_BITS-1:0]  grid_width;
	rule_t               rule;
	gen_row_t            expected_rows [$];
	int                  errors = 0;

	always @(posedge clk or negedge arst_n) begin : track
		gen_row_t            want;
		int                  w, h, yu, yd, xl, xr, count;
		logic [ROW_BITS-1:0] up, mid, down, next;
		logic                alive;
		string               exp_txt, got_txt;
		if (!arst_n) begin
			rows_held = 0;
			overflowed = 1'b0;
			grid_width = RST_GRID_WIDTH;
			rule = '{birth: RST_BIRTH_MASK, death: RST_DEATH_MASK, diag: RST_DIAGONAL};
			expected_rows.delete();
			pending <= 0;
			fail_count <= errors;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_GRID_WIDTH: grid_width = cfg.data[GW_BITS-1:0];
					REG_BIRTH_MASK: rule.birth = cfg.data[MASK_BITS-1:0];
					REG_DEATH_MASK: rule.death = cfg.data[MASK_BITS-1:0];
					REG_DIAGONAL:   rule.diag = cfg.data[0];
					default: ;
				endcase
			end

			if (frame.valid && frame.ready) begin
				// drop rows past the store depth, the final one included
				if (rows_held < STORE_ROWS) begin
					row_store[rows_held] = frame.row_cells;
					rows_held++;
				end else begin
					overflowed = 1'b1;
				end

				if (frame.final_row) begin
					w = (grid_width == 0) ? 1
						: ((grid_width > MAX_W) ? MAX_W : int'(grid_width));
					h = rows_held;
					for (int y = 0; y < h; y++) begin
						yu = (y == 0) ? h - 1 : y - 1;
						yd = (y + 1 == h) ? 0 : y + 1;
						up = row_store[yu];
						mid = row_store[y];
						down = row_store[yd];
						next = '0;
						for (int x = 0; x < w; x++) begin
							// on a one-cell or one-row torus the wrap lands on the cell itself
							xl = (x == 0) ? w - 1 : x - 1;
							xr = (x + 1 == w) ? 0 : x + 1;
							count = int'(up[x]) + int'(mid[xl]) + int'(mid[xr])
								+ int'(down[x]);
							if (rule.diag)
								count += int'(up[xl]) + int'(up[xr])
									+ int'(down[xl]) + int'(down[xr]);
							if (mid[x])
								alive = !rule.death[count];
							else
								alive = rule.birth[count];
							next[x] = alive;
						end
						expected_rows.push_back('{cells: next, last: (y + 1 == h),
							dropped: overflowed});
					end
					rows_held = 0;
					overflowed = 1'b0;
				end
			end

			if (result.valid && result.ready) begin
				if (expected_rows.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("unexpected result beat: cells %h last %0b dropped %0b",
							result.next_cells, result.last_of_frame, result.rows_dropped);
				end else begin
					want = expected_rows.pop_front();
					if (result.next_cells !== want.cells || result.last_of_frame !== want.last
						|| result.rows_dropped !== want.dropped) begin
						errors++;
						if (errors <= MAX_REPORTS) begin
							exp_txt = $sformatf("cells %h last %0b dropped %0b",
								want.cells, want.last, want.dropped);
							got_txt = $sformatf("cells %h last %0b dropped %0b",
								result.next_cells, result.last_of_frame,
								result.rows_dropped);
							$display("row mismatch: expected %s, got %s", exp_txt, got_txt);
						end
					end
				end
			end

			pending <= expected_rows.size();
			fail_count <= errors;
		end
	end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Top of the automaton step testbench: clock, reset, row frames, register phases and sink stalls.
// Depends on tlla_pkg, tlla_if, tlla_step_checker and the block itself.
module tb_top;
	import tlla_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'd4;
	localparam int RANDOM_ITEMS = 220;
	localparam int GEN_LATENCY  = 8;
	localparam int TAIL_CYCLES  = 16;
	localparam int STALL_LIMIT  = 2000;

	logic clk;
	logic arst_n;
	logic quiet;
	logic gaps_on;
	int   stall_left = 0;
	int   fail_count;
	int   pending_rows;

	tlla_in_if  frame_ch ();
	tlla_out_if result_ch ();
	tlla_cfg_if cfg_ch ();

	toroidal_life_like_automaton_step u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.frame  (frame_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	tlla_step_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.frame      (frame_ch),
		.result     (result_ch),
		.cfg        (cfg_ch),
		.fail_count (fail_count),
		.pending    (pending_rows)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// sink side: stall in random bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			result_ch.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!quiet && arst_n && $urandom_range(0, 5) == 0) begin
			result_ch.ready <= 1'b0;
			stall_left <= $urandom_range(0, 5);
		end else begin
			result_ch.ready <= 1'b1;
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		@(posedge arst_n);
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((frame_ch.valid && frame_ch.ready) || (result_ch.valid && result_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("toroidal_life_like_automaton_step test failed");
		$finish;
	end

	function automatic logic [ROW_BITS-1:0] pick_row();
		logic [ROW_BITS-1:0] a, b;
		a = {$urandom, $urandom};
		b = {$urandom, $urandom};
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return a & b;
			3: return a & b & {$urandom, $urandom};
			4: return a | b;
			default: return a;
		endcase
	endfunction

	// one row beat; hold valid into the next row unless a gap or a drop is asked
	task automatic send_row(input logic [ROW_BITS-1:0] cells, input logic fin,
		input logic drop_valid);
		logic gap;
		frame_ch.valid <= 1'b1;
		frame_ch.row_cells <= cells;
		frame_ch.final_row <= fin;
		@(posedge clk);
		while (!frame_ch.ready) @(posedge clk);
		gap = gaps_on && !quiet && ($urandom_range(0, 3) == 0);
		if (drop_valid || gap) begin
			frame_ch.valid <= 1'b0;
			if (gap) repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value, input logic last);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		if (last) cfg_ch.valid <= 1'b0;
	endtask

	task automatic program_rules(input logic [GW_BITS-1:0] gw,
		input logic [MASK_BITS-1:0] birth, input logic [MASK_BITS-1:0] death,
		input logic diag);
		cfg_write(REG_GRID_WIDTH, {9'($urandom), gw}, 1'b0);
		cfg_write(REG_BIRTH_MASK, {7'($urandom), birth}, 1'b0);
		cfg_write(REG_DEATH_MASK, {7'($urandom), death}, 1'b0);
		cfg_write(REG_DIAGONAL, {15'($urandom), diag}, 1'b1);
	endtask

	// wait for the generation to drain, then give the pipeline time to empty
	task automatic settle();
		do @(posedge clk); while (pending_rows != 0);
		repeat (GEN_LATENCY) @(posedge clk);
	endtask

	initial begin : stimulus
		int                   items;
		int                   frame_no;
		int                   h;
		logic [GW_BITS-1:0]   gw;
		logic [MASK_BITS-1:0] birth, death;
		frame_ch.valid <= 1'b0;
		frame_ch.row_cells <= '0;
		frame_ch.final_row <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= '0;
		cfg_ch.data <= '0;
		arst_n <= 1'b0;
		quiet = 1'b0;
		gaps_on = 1'b1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset rule set, full width: blank, full and edge-wrapping rows
		send_row('0, 1'b0, 1'b0);
		send_row('1, 1'b0, 1'b0);
		send_row(64'h8000_0000_0000_0001, 1'b1, 1'b0);
		send_row(pick_row(), 1'b1, 1'b0);
		send_row(pick_row(), 1'b0, 1'b0);
		send_row(pick_row(), 1'b1, 1'b1);

		// one-cell-wide grid: every left and right neighbour is the cell itself
		settle();
		program_rules(7'd1, 9'h001, 9'h100, 1'b1);
		send_row(64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 1'b0);
		send_row(64'h1, 1'b0, 1'b0);
		send_row(64'h0, 1'b1, 1'b1);

		// zero width acts as one
		settle();
		program_rules(7'd0, 9'h0AA, 9'h155, 1'b0);
		send_row('1, 1'b1, 1'b1);

		// width above the maximum acts as the maximum
		settle();
		program_rules(7'd127, 9'h1FF, 9'h000, 1'b1);
		send_row(pick_row(), 1'b0, 1'b0);
		send_row(pick_row(), 1'b0, 1'b0);
		send_row(pick_row(), 1'b1, 1'b1);

		// narrow grid, orthogonal neighbours only; high bits must be ignored
		settle();
		program_rules(7'd5, 9'h000, 9'h1FF, 1'b0);
		send_row({$urandom, $urandom}, 1'b0, 1'b0);
		send_row(64'hFFFF_FFFF_FFFF_FFE0, 1'b0, 1'b0);
		send_row({$urandom, $urandom}, 1'b0, 1'b0);
		send_row(64'h0000_0000_0000_001F, 1'b1, 1'b1);

		// an unmapped index must change nothing
		settle();
		cfg_write(REG_SPARE, 16'hFFFF, 1'b0);
		program_rules(RST_GRID_WIDTH, RST_BIRTH_MASK, RST_DEATH_MASK, RST_DIAGONAL);

		items = 0;
		frame_no = 0;
		while (items < RANDOM_ITEMS) begin
			if (items >= (RANDOM_ITEMS * 3) / 4) quiet = 1'b1;
			if (frame_no % 4 == 0) begin
				settle();
				gaps_on = ($urandom_range(0, 3) != 0);
				case ($urandom_range(0, 9))
					0: gw = 7'd1;
					1: gw = 7'd2;
					2: gw = 7'd64;
					3: gw = 7'd63;
					4: gw = 7'd0;
					5: gw = 7'd127;
					default: gw = 7'($urandom_range(1, 64));
				endcase
				case ($urandom_range(0, 5))
					0: birth = '0;
					1: birth = '1;
					2: birth = RST_BIRTH_MASK;
					default: birth = 9'($urandom_range(0, 511));
				endcase
				case ($urandom_range(0, 5))
					0: death = '0;
					1: death = '1;
					2: death = RST_DEATH_MASK;
					default: death = 9'($urandom_range(0, 511));
				endcase
				program_rules(gw, birth, death, 1'($urandom));
			end

			// mostly short frames; at least one full store and one overflowing frame
			if (frame_no == 2)
				h = 66;
			else if (frame_no == 5)
				h = 64;
			else case ($urandom_range(0, 19))
				0: h = 64;
				1: h = $urandom_range(65, 67);
				default: h = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16)
					: $urandom_range(1, 5);
			endcase

			for (int r = 0; r < h; r++)
				send_row(pick_row(), r == h - 1,
					(r == h - 1)
					&& (((frame_no + 1) % 4 == 0) || (items + h >= RANDOM_ITEMS)));
			items += h;
			frame_no++;
		end

		do @(posedge clk); while (pending_rows != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("toroidal_life_like_automaton_step test passed");
		else
			$display("toroidal_life_like_automaton_step test failed");
		$finish;
	end

endmodule
